// File: hdl/pts_pkg.sv
`default_nettype none

package pts_pkg;

    // Field widths of one item
    localparam int PRIO_W = 16;
    localparam int ID_W   = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam int DEPTH_DEFAULT = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_FLIGHT = 2'd3;

    // Most negative priority, floor of the decrement on reinsert
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [PRIO_W-1:0] priority_req;
        logic [ID_W-1:0]          task_id;
        logic                     still_running;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [ID_W-1:0]          out_task_id;
        logic signed [PRIO_W-1:0] out_priority;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

    // One stored task
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [ID_W-1:0]          id;
    } entry_t;

endpackage

`default_nettype wire

// File: hdl/pts_mem.sv
`default_nettype none

module pts_mem #(
    parameter int DEPTH = pts_pkg::DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire pts_pkg::entry_t  wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output pts_pkg::entry_t       rd_data
);
    import pts_pkg::*;

    entry_t mem [DEPTH];

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/pts_cmp.sv
`default_nettype none

module pts_cmp (
    input  wire pts_pkg::entry_t cand,
    input  wire pts_pkg::entry_t best,
    input  wire logic            best_found,
    output logic                 better
);
    import pts_pkg::*;

    logic prio_gt;
    logic prio_eq;
    logic id_gt;

    // Higher priority wins, then larger id; a full tie keeps the earlier slot
    assign prio_gt = $signed(cand.prio) > $signed(best.prio);
    assign prio_eq = cand.prio == best.prio;
    assign id_gt   = cand.id > best.id;
    assign better  = !best_found || prio_gt || (prio_eq && id_gt);

endmodule

`default_nettype wire

// File: hdl/priority_task_scheduler_top.sv
`default_nettype none

// Priority task scheduler: one item at a time; the next is taken as the result shows.
// Refused adds, empty or repeated dispatches, reports of finished tasks and unused codes
// answer in the next cycle. An add or reinsert walks the slots for a free one.
// A dispatch scans every slot through one comparator.
// The result strobe is one cycle wide; the receiver cannot stall it.
// Reset empties the queue, clears the in-flight task and update_mode; no clearing pass.
module priority_task_scheduler_top #(
    parameter int DEPTH = pts_pkg::DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pts_pkg::in_item_t in_item,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    output logic               done,
    output pts_pkg::result_t   result
);
    import pts_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t             state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [DEPTH-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]   queued_reg, queued_next;
    logic               flight_reg, flight_next;
    entry_t             fl_reg, fl_next;
    entry_t             ins_reg, ins_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    entry_t             best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               best_found_reg, best_found_next;
    logic               done_reg, done_next;
    result_t            res_reg, res_next;

    logic               mem_we;
    entry_t             rd_data;
    logic               cand_better;
    logic               take_cand;
    logic [CNT_W:0]     in_use;

    pts_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_data (ins_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    pts_cmp u_cmp (
        .cand       (rd_data),
        .best       (best_reg),
        .best_found (best_found_reg),
        .better     (cand_better)
    );

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

    assign in_use    = {1'b0, queued_reg} + (CNT_W + 1)'(flight_reg);
    assign take_cand = rd_pend_reg && rd_ok_reg && cand_better;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = cfg_we ? cfg_wdata : mode_reg;
        valid_next      = valid_reg;
        queued_next     = queued_reg;
        flight_next     = flight_reg;
        fl_next         = fl_reg;
        ins_next        = ins_reg;
        idx_next        = idx_reg;
        rd_pend_next    = 1'b0;
        rd_ok_next      = rd_ok_reg;
        rd_idx_next     = rd_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        mem_we          = 1'b0;

        // Fold the slot arriving from memory into the running maximum
        if (take_cand)
        begin
            best_next       = rd_data;
            best_idx_next   = rd_idx_reg;
            best_found_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    done_next       = 1'b1;
                    res_next        = '{status: ST_OK, out_task_id: '0, out_priority: '0,
                                        occupancy: OCC_W'(queued_reg)};
                    case (in_item.cmd)
                        CMD_ADD:
                        begin
                            if (in_use >= (CNT_W + 1)'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ins_next   = '{prio: in_item.priority_req, id: in_item.task_id};
                                done_next  = 1'b0;
                                state_next = S_FIND;
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            if (flight_reg)
                            begin
                                res_next.out_task_id  = fl_reg.id;
                                res_next.out_priority = fl_reg.prio;
                            end
                            else if (queued_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_REPORT:
                        begin
                            if (!flight_reg)
                            begin
                                res_next.status = ST_NO_FLIGHT;
                            end
                            else
                            begin
                                flight_next = 1'b0;
                                fl_next     = '0;
                                if (in_item.still_running)
                                begin
                                    ins_next.id   = fl_reg.id;
                                    ins_next.prio = (mode_reg && fl_reg.prio != PRIO_MIN)
                                                    ? fl_reg.prio - PRIO_W'(1) : fl_reg.prio;
                                    done_next     = 1'b0;
                                    state_next    = S_FIND;
                                end
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            // Walk the slots for the first free one and store the task there
            S_FIND:
            begin
                if (!valid_reg[idx_reg])
                begin
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    queued_next         = queued_reg + CNT_W'(1);
                    done_next           = 1'b1;
                    res_next            = '{status: ST_OK, out_task_id: '0, out_priority: '0,
                                            occupancy: OCC_W'(queued_reg + CNT_W'(1))};
                    state_next          = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Issue one slot read a cycle
            S_SCAN:
            begin
                rd_pend_next = 1'b1;
                rd_ok_next   = valid_reg[idx_reg];
                rd_idx_next  = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Last slot compared: move the winner in flight
            S_DRAIN:
            begin
                valid_next[best_idx_next] = 1'b0;
                queued_next               = queued_reg - CNT_W'(1);
                flight_next               = 1'b1;
                fl_next                   = best_next;
                done_next                 = 1'b1;
                res_next                  = '{status: ST_OK, out_task_id: best_next.id,
                                              out_priority: best_next.prio,
                                              occupancy: OCC_W'(queued_reg - CNT_W'(1))};
                state_next                = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= 1'b0;
            valid_reg      <= '0;
            queued_reg     <= '0;
            flight_reg     <= 1'b0;
            fl_reg         <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            valid_reg      <= valid_next;
            queued_reg     <= queued_next;
            flight_reg     <= flight_next;
            fl_reg         <= fl_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ins_reg      <= ins_next;
        idx_reg      <= idx_next;
        rd_ok_reg    <= rd_ok_next;
        rd_idx_reg   <= rd_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
    end

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(queued_reg))
        else $error("queued count differs from number of valid slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_use <= (CNT_W + 1)'(DEPTH))
        else $error("queued plus in-flight tasks exceed the depth");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.cmd == CMD_ADD && in_use >= (CNT_W + 1)'(DEPTH))
        |=> (done && result.status == ST_FULL && $stable(queued_reg)))
        else $error("add at full not refused at once");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK)
        |-> (result.out_task_id == '0 && result.out_priority == '0))
        else $error("failed command returned a task");
`endif

endmodule

`default_nettype wire

// File: bench/priority_task_scheduler_top_tb.sv
`default_nettype none

module priority_task_scheduler_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN = 10;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    in_item_t in_item;
    logic     cfg_we;
    logic     cfg_wdata;
    logic     done;
    result_t  result;

    // Scheduler state mirrored by the predictor
    logic signed [PRIO_W-1:0] slot_prio [DEPTH];
    logic [ID_W-1:0]          slot_id   [DEPTH];
    bit                       slot_used [DEPTH];
    int                       queued_tasks;
    bit                       flight_valid;
    logic [ID_W-1:0]          flight_id;
    logic signed [PRIO_W-1:0] flight_prio;
    bit                       lower_on_reinsert;

    result_t pending_results[$];
    result_t want_r;
    result_t chk_r;
    int      mismatches;
    int      items_sent;
    int      results_checked;
    int      status_seen [4];
    int      quiet_cycles;

    priority_task_scheduler_top #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Place a task in the lowest free slot
    function automatic void store_task(logic signed [PRIO_W-1:0] p, logic [ID_W-1:0] id);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!slot_used[i])
            begin
                slot_used[i] = 1'b1;
                slot_prio[i] = p;
                slot_id[i]   = id;
                queued_tasks++;
                return;
            end
        end
    endfunction

    // Apply one command to the mirrored state and return the result it gives
    function automatic result_t schedule_step(in_item_t it);
        result_t r;
        int best;
        logic signed [PRIO_W-1:0] p;
        r = '0;
        best = -1;
        case (it.cmd)
            CMD_ADD:
            begin
                if (queued_tasks + int'(flight_valid) >= DEPTH)
                    r.status = ST_FULL;
                else
                    store_task(it.priority_req, it.task_id);
            end
            CMD_DISPATCH:
            begin
                if (flight_valid)
                begin
                    r.out_task_id  = flight_id;
                    r.out_priority = flight_prio;
                end
                else
                begin
                    // Highest priority, then larger id, then lowest slot
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (slot_used[i] && (best < 0 || slot_prio[i] > slot_prio[best] ||
                            (slot_prio[i] == slot_prio[best] && slot_id[i] > slot_id[best])))
                            best = i;
                    end
                    if (best < 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        slot_used[best] = 1'b0;
                        queued_tasks--;
                        flight_valid   = 1'b1;
                        flight_id      = slot_id[best];
                        flight_prio    = slot_prio[best];
                        r.out_task_id  = flight_id;
                        r.out_priority = flight_prio;
                    end
                end
            end
            CMD_REPORT:
            begin
                if (!flight_valid)
                    r.status = ST_NO_FLIGHT;
                else
                begin
                    if (it.still_running)
                    begin
                        p = flight_prio;
                        if (lower_on_reinsert && p != PRIO_MIN)
                            p = p - 1'b1;
                        store_task(p, flight_id);
                    end
                    flight_valid = 1'b0;
                    flight_id    = '0;
                    flight_prio  = '0;
                end
            end
            default: ;
        endcase
        r.occupancy = queued_tasks[OCC_W-1:0];
        return r;
    endfunction

    // Predict on every accepted item
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            want_r = schedule_step(in_item);
            status_seen[want_r.status]++;
            pending_results.push_back(want_r);
            items_sent++;
        end
    end

    // Check each result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("[%0t] result with no item pending: status %0d id %0d prio %0d",
                             $realtime, result.status, result.out_task_id,
                             result.out_priority);
            end
            else
            begin
                chk_r = pending_results.pop_front();
                if (result.status !== chk_r.status ||
                    result.out_task_id !== chk_r.out_task_id ||
                    result.out_priority !== chk_r.out_priority ||
                    result.occupancy !== chk_r.occupancy)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("[%0t] result %0d mismatch (expected/actual):",
                                 $realtime, results_checked);
                        $display("    status %0d/%0d id %0d/%0d prio %0d/%0d occupancy %0d/%0d",
                                 chk_r.status, result.status,
                                 chk_r.out_task_id, result.out_task_id,
                                 chk_r.out_priority, result.out_priority,
                                 chk_r.occupancy, result.occupancy);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: %0d cycles without progress, %0d results pending",
                         quiet_cycles, pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [PRIO_W-1:0] p,
                             logic [ID_W-1:0] id, logic running);
        @(negedge clk);
        start                 <= 1'b1;
        in_item.cmd           <= cmd;
        in_item.priority_req  <= p;
        in_item.task_id       <= id;
        in_item.still_running <= running;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start for a random number of cycles
    task automatic sender_gap(int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Hold off until every pending result has come and the block is idle
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_update_mode(logic mode);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
        lower_on_reinsert = mode;
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            0: case ($urandom_range(4))
                   0: return PRIO_MIN;
                   1: return PRIO_MIN + 1'b1;
                   2: return PRIO_MAX;
                   3: return '1;
                   default: return '0;
               endcase
            1: return PRIO_W'($signed($urandom_range(4)) - 2);
            default: return PRIO_W'($urandom());
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(3))
            0: return ($urandom_range(1) != 0) ? '1 : '0;
            1: return ID_W'($urandom_range(3));
            default: return ID_W'($urandom());
        endcase
    endfunction

    // Status codes: no flight, empty queue, unused code, repeated dispatch
    task automatic test_status_corners();
        send_item(CMD_REPORT, PRIO_MAX, '1, 1'b1);
        send_item(CMD_DISPATCH, PRIO_MIN, '1, 1'b0);
        send_item(CMD_UNUSED, '1, '1, 1'b1);
        send_item(CMD_ADD, PRIO_MAX, '0, 1'b0);
        send_item(CMD_DISPATCH, '0, '0, 1'b0);
        send_item(CMD_DISPATCH, '0, '0, 1'b0);
        send_item(CMD_REPORT, '0, '0, 1'b1);
        send_item(CMD_DISPATCH, '0, '0, 1'b0);
        send_item(CMD_REPORT, '0, '0, 1'b0);
        wait_drained();
    endtask

    // Equal priorities go to the larger id, duplicates both come out
    task automatic test_tie_order();
        send_item(CMD_ADD, 16'sd5, 8'd10, 1'b0);
        send_item(CMD_ADD, 16'sd5, 8'd200, 1'b0);
        send_item(CMD_ADD, 16'sd5, 8'd200, 1'b0);
        send_item(CMD_ADD, -16'sd1, 8'd128, 1'b0);
        send_item(CMD_ADD, PRIO_MIN, '1, 1'b0);
        repeat (4)
        begin
            send_item(CMD_DISPATCH, '0, '0, 1'b0);
            send_item(CMD_REPORT, '0, '0, 1'b0);
        end
        wait_drained();
    endtask

    // Lowering on reinsert holds at the most negative priority
    task automatic test_reinsert_floor();
        set_update_mode(1'b1);
        send_item(CMD_DISPATCH, '0, '0, 1'b0);
        send_item(CMD_REPORT, '0, '0, 1'b1);
        send_item(CMD_DISPATCH, '0, '0, 1'b0);
        send_item(CMD_REPORT, '0, '0, 1'b0);
        wait_drained();
    endtask

    // Mostly add / dispatch / report flows, with noise and unused codes
    task automatic test_random_traffic(int count, int idle_pct, logic mode);
        int add_w;
        int r;
        logic [CMD_W-1:0] cmd;
        set_update_mode(mode);
        add_w = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                add_w = 25 * (1 + $urandom_range(2));
            r = $urandom_range(99);
            if (r < 3)
                cmd = CMD_UNUSED;
            else if (r < 13)
                cmd = CMD_W'($urandom_range(2));
            else if (r < 13 + add_w)
                cmd = CMD_ADD;
            else
                cmd = flight_valid ? CMD_REPORT : CMD_DISPATCH;
            sender_gap(idle_pct);
            send_item(cmd, pick_prio(), pick_id(), 1'($urandom()));
            if ($urandom_range(99) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
            slot_prio[i] = '0;
            slot_id[i]   = '0;
        end
        queued_tasks      = 0;
        flight_valid      = 1'b0;
        flight_id         = '0;
        flight_prio       = '0;
        lower_on_reinsert = 1'b0;
        mismatches        = 0;
        items_sent        = 0;
        results_checked   = 0;
        quiet_cycles      = 0;
        status_seen       = '{default: 0};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_status_corners();
        test_tie_order();
        test_reinsert_floor();
        test_random_traffic(405, 0, 1'b0);
        test_random_traffic(405, 85, 1'b1);
        test_random_traffic(405, 24, 1'b0);
        test_random_traffic(405, 0, 1'b1);

        // Let any stray result show up
        repeat (DEPTH + 4) @(posedge clk);
        if (pending_results.size() != 0)
            mismatches++;

        $display("%0d items, %0d results checked, %0d mismatches; status ok %0d, empty %0d,",
                 items_sent, results_checked, mismatches, status_seen[ST_OK],
                 status_seen[ST_EMPTY]);
        $display("full %0d, nothing in flight %0d; both update modes, idle phases 0/24/85",
                 status_seen[ST_FULL], status_seen[ST_NO_FLIGHT]);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: priority_task_scheduler_top.f
hdl/pts_pkg.sv
hdl/pts_mem.sv
hdl/pts_cmp.sv
hdl/priority_task_scheduler_top.sv
bench/priority_task_scheduler_top_tb.sv
